@@ hw/rtl/sorted_waiter_wakeup_queue_core_assert.svh @@
// assertion macros for the sorted waiter wake-up queue
// no dependencies; included by the core file, which checks its own logic
`ifndef SORTED_WAITER_WAKEUP_QUEUE_CORE_ASSERT_SVH
`define SORTED_WAITER_WAKEUP_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SWQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SWQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/swq_pkg.sv @@
// shared types and constants for the sorted waiter wake-up queue
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package swq_pkg;

    localparam int WAITER_SLOTS = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int POS_W        = 64;
    localparam int ID_W         = 10;
    localparam int MODE_W       = 2;
    localparam int KIND_W       = 3;
    localparam int REM_W        = 6;
    localparam int CNT_W        = $clog2(WAITER_SLOTS + 1);
    localparam int REL_W        = $clog2(MAX_RESULTS + 1);

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [REM_W-1:0]  t_rem;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [REL_W-1:0]  t_rel;

    localparam t_pos POS_ALL_ONES = {POS_W{1'b1}};

    localparam t_mode MODE_ADD = 2'd0;
    localparam t_mode MODE_DEL = 2'd1;
    localparam t_mode MODE_ADV = 2'd2;

    localparam t_kind KIND_ADDED    = 3'd0;
    localparam t_kind KIND_FULL     = 3'd1;
    localparam t_kind KIND_REMOVED  = 3'd2;
    localparam t_kind KIND_NOTFOUND = 3'd3;
    localparam t_kind KIND_WOKEN    = 3'd4;
    localparam t_kind KIND_NONE     = 3'd5;

    // cell operations
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD = 2'd0;
    localparam t_cell_op CELL_ADD  = 2'd1;
    localparam t_cell_op CELL_DEL  = 2'd2;
    localparam t_cell_op CELL_POP  = 2'd3;

    typedef struct packed {
        t_cell_op op;
        t_pos     target;
        t_id      owner;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/swq_if.sv @@
// valid/ready channel interfaces for the sorted waiter wake-up queue
// depends on swq_pkg
`default_nettype none

interface swq_in_if import swq_pkg::*; ();
    logic  valid;
    logic  ready;
    t_mode mode;
    t_id   waiter_id;
    t_pos  position;

    modport source (output valid, output mode, output waiter_id, output position,
                    input ready);
    modport sink   (input valid, input mode, input waiter_id, input position,
                    output ready);
endinterface

interface swq_out_if import swq_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind kind;
    t_id   woken_id;
    t_pos  min_target;
    t_rem  remaining;
    logic  last;

    modport source (output valid, output kind, output woken_id, output min_target,
                    output remaining, output last, input ready);
    modport sink   (input valid, input kind, input woken_id, input min_target,
                    input remaining, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/swq_cell.sv @@
// one slot of the sorted chain: holds a target and an owner id
// depends on swq_pkg; instantiated in a row by the top level
`default_nettype none

module swq_cell import swq_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_occ,
    input  wire logic      i_at_end,
    input  wire logic      i_left_ge,
    input  wire t_pos      i_left_target,
    input  wire t_id       i_left_owner,
    input  wire t_pos      i_right_target,
    input  wire t_id       i_right_owner,
    input  wire logic      i_hit_in,
    output logic           o_ge,
    output logic           o_hit,
    output t_pos           o_target,
    output t_id            o_owner
);

    t_pos r_target;
    t_id  r_owner;
    t_pos n_target;
    t_id  n_owner;
    logic w_match;

    assign o_ge     = i_occ && (r_target >= i_ctl.target);
    assign w_match  = i_occ && (r_owner == i_ctl.owner);
    assign o_hit    = i_hit_in | w_match;
    assign o_target = r_target;
    assign o_owner  = r_owner;

    always_comb begin
        n_target = r_target;
        n_owner  = r_owner;
        case (i_ctl.op)
            CELL_ADD: begin
                // list is sorted, so everything right of the insertion point moves up
                if (i_left_ge) begin
                    n_target = i_left_target;
                    n_owner  = i_left_owner;
                end else if (o_ge || i_at_end) begin
                    n_target = i_ctl.target;
                    n_owner  = i_ctl.owner;
                end
            end
            CELL_DEL: begin
                // first match at or left of here closes the gap
                if (o_hit) begin
                    n_target = i_right_target;
                    n_owner  = i_right_owner;
                end
            end
            CELL_POP: begin
                n_target = i_right_target;
                n_owner  = i_right_owner;
            end
            default: begin
                n_target = r_target;
                n_owner  = r_owner;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_owner  <= n_owner;
    end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_waiter_wakeup_queue_core.sv @@
// Sorted waiter wake-up queue. Holds up to WAITER_SLOTS waiters in a row of
// cells kept in ascending target order; each cell compares its own target
// and id against the broadcast request and takes data from a neighbour, so
// an add or a remove updates the whole list at once when it is accepted.
// Add and remove then register their result when the result channel is
// free. An advance is accepted and then releases one waiter per cycle
// while the result channel is free, since the chain shifts by one slot per
// release; an advance that releases nothing gives a single result.
// Backpressure on the result channel holds each step. A new input is
// taken as soon as the last result of the previous one sits in the output
// register. No clearing pass after reset.
// depends on swq_pkg, swq_if, swq_cell and the assertion macro header
`default_nettype none

`include "sorted_waiter_wakeup_queue_core_assert.svh"

module sorted_waiter_wakeup_queue_core import swq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    swq_in_if.sink    i_in,
    swq_out_if.source o_out
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RESULT = 2'd1;
    localparam logic [1:0] S_ADV    = 2'd2;

    logic [1:0] r_state, n_state;
    t_cnt       r_count, n_count;
    t_rel       r_nrel, n_nrel;
    t_pos       r_pos, n_pos;
    t_kind      r_kind, n_kind;

    logic       r_out_valid, n_out_valid;
    t_kind      r_out_kind, n_out_kind;
    t_id        r_out_id, n_out_id;
    t_pos       r_out_min, n_out_min;
    t_rem       r_out_rem, n_out_rem;
    logic       r_out_last, n_out_last;

    t_cell_ctl  w_ctl;
    logic       w_accept;
    logic       w_out_free;
    logic       w_pop;
    logic       w_more;
    t_cnt       w_cnt_dec;

    logic [WAITER_SLOTS-1:0] w_ge;
    logic [WAITER_SLOTS-1:0] w_hit;
    t_pos                    w_target [WAITER_SLOTS];
    t_id                     w_owner  [WAITER_SLOTS];

    // row of cells
    for (genvar g = 0; g < WAITER_SLOTS; g++) begin : g_cell
        logic w_left_ge;
        t_pos w_left_target;
        t_id  w_left_owner;
        t_pos w_right_target;
        t_id  w_right_owner;
        logic w_hit_in;

        if (g == 0) begin : g_head
            assign w_left_ge     = 1'b0;
            assign w_left_target = w_target[g];
            assign w_left_owner  = w_owner[g];
            assign w_hit_in      = 1'b0;
        end else begin : g_body
            assign w_left_ge     = w_ge[g-1];
            assign w_left_target = w_target[g-1];
            assign w_left_owner  = w_owner[g-1];
            assign w_hit_in      = w_hit[g-1];
        end

        if (g == WAITER_SLOTS - 1) begin : g_tail
            assign w_right_target = w_target[g];
            assign w_right_owner  = w_owner[g];
        end else begin : g_inner
            assign w_right_target = w_target[g+1];
            assign w_right_owner  = w_owner[g+1];
        end

        swq_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_occ          (CNT_W'(g) < r_count),
            .i_at_end       (CNT_W'(g) == r_count),
            .i_left_ge      (w_left_ge),
            .i_left_target  (w_left_target),
            .i_left_owner   (w_left_owner),
            .i_right_target (w_right_target),
            .i_right_owner  (w_right_owner),
            .i_hit_in       (w_hit_in),
            .o_ge           (w_ge[g]),
            .o_hit          (w_hit[g]),
            .o_target       (w_target[g]),
            .o_owner        (w_owner[g])
        );
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_cnt_dec  = r_count - CNT_W'(1);

    // head release test and look-ahead at the next head for the last flag
    assign w_pop  = (r_count != '0) && (w_target[0] <= r_pos);
    assign w_more = (r_count > CNT_W'(1)) && (w_target[1] <= r_pos);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_nrel      = r_nrel;
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_min   = r_out_min;
        n_out_rem   = r_out_rem;
        n_out_last  = r_out_last;
        w_ctl.op     = CELL_HOLD;
        w_ctl.target = i_in.position;
        w_ctl.owner  = i_in.waiter_id;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.mode)
                        MODE_ADD: begin
                            n_state = S_RESULT;
                            if (r_count >= CNT_W'(WAITER_SLOTS)) begin
                                n_kind = KIND_FULL;
                            end else begin
                                w_ctl.op = CELL_ADD;
                                n_count  = r_count + CNT_W'(1);
                                n_kind   = KIND_ADDED;
                            end
                        end
                        MODE_DEL: begin
                            n_state  = S_RESULT;
                            w_ctl.op = CELL_DEL;
                            if (w_hit[WAITER_SLOTS-1]) begin
                                n_count = w_cnt_dec;
                                n_kind  = KIND_REMOVED;
                            end else begin
                                n_kind  = KIND_NOTFOUND;
                            end
                        end
                        MODE_ADV: begin
                            n_state = S_ADV;
                            n_pos   = i_in.position;
                            n_nrel  = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_id    = '0;
                    n_out_min   = (r_count != '0) ? w_target[0] : POS_ALL_ONES;
                    n_out_rem   = REM_W'(r_count);
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ADV: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_pop) begin
                        w_ctl.op   = CELL_POP;
                        n_count    = w_cnt_dec;
                        n_nrel     = r_nrel + REL_W'(1);
                        n_out_kind = KIND_WOKEN;
                        n_out_id   = w_owner[0];
                        n_out_min  = (r_count > CNT_W'(1)) ? w_target[1] : POS_ALL_ONES;
                        n_out_rem  = REM_W'(w_cnt_dec);
                        n_out_last = !w_more || (r_nrel == REL_W'(MAX_RESULTS - 1));
                        if (n_out_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        // only reached before any release
                        n_out_kind = KIND_NONE;
                        n_out_id   = '0;
                        n_out_min  = (r_count != '0) ? w_target[0] : POS_ALL_ONES;
                        n_out_rem  = REM_W'(r_count);
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_nrel      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_nrel      <= n_nrel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_kind     <= n_kind;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_min  <= n_out_min;
        r_out_rem  <= n_out_rem;
        r_out_last <= n_out_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.woken_id   = r_out_id;
    assign o_out.min_target = r_out_min;
    assign o_out.remaining  = r_out_rem;
    assign o_out.last       = r_out_last;

    `SWQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(WAITER_SLOTS), "waiter count beyond slot count")
    `SWQ_ASSERT_NOW(a_head_sorted, i_clk, i_rst_n, r_count > CNT_W'(1),
        w_target[0] <= w_target[1], "head of list out of order")
    `SWQ_ASSERT_NXT(a_pop_dec, i_clk, i_rst_n, (r_state == S_ADV) && w_out_free && w_pop,
        r_count == $past(w_cnt_dec), "release did not shrink the list by one")
    `SWQ_ASSERT_NXT(a_result_done, i_clk, i_rst_n, (r_state == S_RESULT) && w_out_free,
        (r_state == S_IDLE) && r_out_valid && r_out_last,
        "add or remove transaction did not finish")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking bench for the sorted waiter wake-up queue: directed and random traffic
// on the request channel, every result transaction checked against an in-bench list model
// depends on swq_pkg, swq_if and sorted_waiter_wakeup_queue_core
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swq_pkg::*;

    localparam t_mode MODE_UNUSED  = 2'd3;
    localparam int    STALL_LIMIT  = 2000;
    localparam int    DRAIN_CYCLES = 2 * MAX_RESULTS + 8;

    typedef struct {
        t_kind kind;
        t_id   woken_id;
        t_pos  min_target;
        t_rem  remaining;
        logic  last;
    } t_wait_result;

    logic clk;
    logic rst_n;
    bit   calm;
    int   mismatches;
    int   stall_cycles;

    // model of the waiter list
    t_pos         list_target[WAITER_SLOTS];
    t_id          list_owner[WAITER_SLOTS];
    int           list_count;
    t_wait_result results_due[$];

    swq_in_if  req_ch ();
    swq_out_if res_ch ();

    sorted_waiter_wakeup_queue_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    always #10 clk = ~clk;

    function automatic t_pos list_min();
        return (list_count != 0) ? list_target[0] : POS_ALL_ONES;
    endfunction

    function automatic void queue_result(t_kind k, t_id who, logic fin);
        t_wait_result r;
        r.kind       = k;
        r.woken_id   = who;
        r.min_target = list_min();
        r.remaining  = t_rem'(list_count);
        r.last       = fin;
        results_due.push_back(r);
    endfunction

    function automatic void drop_slot(int at);
        for (int j = at; j + 1 < list_count; j++) begin
            list_target[j] = list_target[j + 1];
            list_owner[j]  = list_owner[j + 1];
        end
        list_count--;
    endfunction

    function automatic void apply_waiter_op(t_mode m, t_id id, t_pos pos);
        int   at;
        int   n;
        t_id  who;
        bit   more;
        case (m)
            MODE_ADD: begin
                if (list_count >= WAITER_SLOTS) begin
                    queue_result(KIND_FULL, '0, 1'b1);
                end else begin
                    // goes in front of any equal target
                    at = list_count;
                    for (int i = list_count - 1; i >= 0; i--)
                        if (list_target[i] >= pos) at = i;
                    for (int i = list_count; i > at; i--) begin
                        list_target[i] = list_target[i - 1];
                        list_owner[i]  = list_owner[i - 1];
                    end
                    list_target[at] = pos;
                    list_owner[at]  = id;
                    list_count++;
                    queue_result(KIND_ADDED, '0, 1'b1);
                end
            end
            MODE_DEL: begin
                at = -1;
                for (int i = list_count - 1; i >= 0; i--)
                    if (list_owner[i] == id) at = i;
                if (at >= 0) begin
                    drop_slot(at);
                    queue_result(KIND_REMOVED, '0, 1'b1);
                end else begin
                    queue_result(KIND_NOTFOUND, '0, 1'b1);
                end
            end
            MODE_ADV: begin
                n = 0;
                if (list_count == 0 || list_target[0] > pos) begin
                    queue_result(KIND_NONE, '0, 1'b1);
                end else begin
                    more = 1'b1;
                    while (more) begin
                        who = list_owner[0];
                        drop_slot(0);
                        n++;
                        more = (n < MAX_RESULTS) && (list_count != 0) && (list_target[0] <= pos);
                        queue_result(KIND_WOKEN, who, !more);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // one request transaction, with random idle cycles ahead of it unless calm is set
    task automatic send_item(input t_mode m, input t_id id, input t_pos pos);
        while (!calm && $urandom_range(99) < 31) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= m;
        req_ch.waiter_id <= id;
        req_ch.position  <= pos;
        do @(posedge clk); while (!req_ch.ready);
        apply_waiter_op(m, id, pos);
    endtask

    function automatic t_pos rand_target();
        case ($urandom_range(9))
            0:       return '0;
            1:       return POS_ALL_ONES;
            2, 3, 4: return t_pos'($urandom_range(20));
            5:       return POS_ALL_ONES - t_pos'($urandom_range(3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // when the list is not empty, half of the advance positions land on or just below a held target
    function automatic t_pos rand_advance();
        int   r;
        t_pos p;
        r = $urandom_range(9);
        if (list_count != 0 && r < 5) begin
            p = list_target[$urandom_range(list_count - 1)];
            if (p != '0 && $urandom_range(1) == 1) p = p - 1'b1;
            return p;
        end
        if (r == 5) return '0;
        if (r == 6) return POS_ALL_ONES;
        return rand_target();
    endfunction

    function automatic t_id pick_id();
        if ($urandom_range(1) == 1) return t_id'($urandom_range(7));
        return t_id'($urandom_range(1023));
    endfunction

    task automatic test_empty_list();
        send_item(MODE_ADV, '0, '0);
        send_item(MODE_ADV, '1, POS_ALL_ONES);
        send_item(MODE_DEL, '0, '0);
        send_item(MODE_DEL, '1, POS_ALL_ONES);
        send_item(MODE_UNUSED, '1, POS_ALL_ONES);
    endtask

    task automatic test_ordering();
        send_item(MODE_ADD, 10'd1023, '0);
        send_item(MODE_ADD, 10'd0, POS_ALL_ONES);
        send_item(MODE_ADD, 10'd5, '0);
        send_item(MODE_ADD, 10'd7, 64'd100);
        send_item(MODE_ADD, 10'd9, 64'd100);
        send_item(MODE_DEL, 10'd999, '0);
        send_item(MODE_DEL, 10'd0, '0);
        send_item(MODE_ADD, 10'd0, POS_ALL_ONES);
        send_item(MODE_ADV, '0, '0);
        send_item(MODE_ADV, '0, 64'd99);
        send_item(MODE_ADV, '0, 64'd100);
        send_item(MODE_ADV, '0, POS_ALL_ONES - 1'b1);
        send_item(MODE_ADV, '0, POS_ALL_ONES);
    endtask

    // two waiters with one id: remove takes the nearer one
    task automatic test_duplicate_ids();
        send_item(MODE_ADD, 10'd3, 64'd10);
        send_item(MODE_ADD, 10'd3, 64'd20);
        send_item(MODE_DEL, 10'd3, '1);
        send_item(MODE_ADV, '1, POS_ALL_ONES);
    endtask

    task automatic test_fill_and_drain();
        while (list_count < WAITER_SLOTS)
            send_item(MODE_ADD, pick_id(), rand_target());
        send_item(MODE_ADD, pick_id(), rand_target());
        send_item(MODE_ADV, pick_id(), POS_ALL_ONES);
    endtask

    task automatic test_random_mix(input int n_items);
        int   r;
        int   add_share;
        t_id  id;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            // alternate between filling and draining phases
            add_share = ((i / 40) % 2 == 1) ? 70 : 42;
            if (r < 3) begin
                send_item(MODE_UNUSED, t_id'($urandom_range(1023)), {$urandom, $urandom});
            end else if (r < 3 + add_share) begin
                send_item(MODE_ADD, pick_id(), rand_target());
            end else if (r < 23 + add_share) begin
                if (list_count != 0 && $urandom_range(9) < 8)
                    id = list_owner[$urandom_range(list_count - 1)];
                else
                    id = t_id'($urandom_range(1023));
                send_item(MODE_DEL, id, {$urandom, $urandom});
            end else begin
                send_item(MODE_ADV, t_id'($urandom_range(1023)), rand_advance());
            end
        end
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        test_fill_and_drain();
        test_random_mix(40);
        calm = 1'b0;
    endtask

    always @(negedge clk)
        res_ch.ready <= calm || ($urandom_range(99) >= 31);

    always @(posedge clk) begin : check_results
        t_wait_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (results_due.size() == 0) begin
                $error("result transaction with none outstanding: kind %0d", res_ch.kind);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (res_ch.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
                    mismatches++;
                end
                if (res_ch.woken_id !== want.woken_id) begin
                    $error("woken_id: expected %0d, got %0d", want.woken_id, res_ch.woken_id);
                    mismatches++;
                end
                if (res_ch.min_target !== want.min_target) begin
                    $error("min_target: expected %h, got %h", want.min_target, res_ch.min_target);
                    mismatches++;
                end
                if (res_ch.remaining !== want.remaining) begin
                    $error("remaining: expected %0d, got %0d", want.remaining, res_ch.remaining);
                    mismatches++;
                end
                if (res_ch.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, res_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // cycles with no transaction on either channel
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("sorted_waiter_wakeup_queue_core: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        calm             = 1'b0;
        mismatches       = 0;
        stall_cycles     = 0;
        list_count       = 0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_ADD;
        req_ch.waiter_id = '0;
        req_ch.position  = '0;
        res_ch.ready     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_ordering();
        test_duplicate_ids();
        test_fill_and_drain();
        test_random_mix(300);
        test_back_to_back();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("sorted_waiter_wakeup_queue_core: match");
        end else begin
            $display("sorted_waiter_wakeup_queue_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/swq_pkg.sv
hw/rtl/swq_if.sv
hw/rtl/swq_cell.sv
hw/rtl/sorted_waiter_wakeup_queue_core.sv
tb/tb_top.sv
